### design/tkc_pkg.sv
package tkc_pkg;

    // Width of one kernel tap and of one result tap.
    localparam int TAP_W = 16;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } tkc_state_t;

    // Controls from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic issue;  // a tap pair read is issued this cycle
        logic clear;  // zero the accumulator
    } tkc_mac_ctl_t;

endpackage

### design/tkc_ram.sv
module tkc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/tkc_mac.sv
module tkc_mac #(
    parameter int TAPS      = 64,
    parameter int FRAC_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tkc_pkg::tkc_mac_ctl_t             ctl,
    input  logic signed [tkc_pkg::TAP_W-1:0]  a_q,
    input  logic signed [tkc_pkg::TAP_W-1:0]  b_q,
    output logic signed [tkc_pkg::TAP_W-1:0]  res_tap,
    output logic                              res_clip
);

    localparam int PROD_W = 2 * tkc_pkg::TAP_W;
    // One spare bit keeps the rounding add from overflowing.
    localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
    localparam int RES_W  = ACC_W - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND =
        {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    logic signed [ACC_W-1:0]          rnd_sum;
    logic        [RES_W-1:0]          res;
    logic        [RES_W-tkc_pkg::TAP_W:0] res_hi;

    // The valid flags follow the tap pair through the memory read and the
    // product register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_q * b_q;
        acc_reg  <= acc_next;
    end

    // Round half up, floor shift, then clamp to the tap range.
    always_comb
    begin
        rnd_sum  = acc_reg + ROUND;
        res      = rnd_sum[ACC_W-1:FRAC_BITS];
        res_hi   = res[RES_W-1:tkc_pkg::TAP_W-1];
        res_clip = !((&res_hi) || (~|res_hi));
        if (!res_clip)
        begin
            res_tap = res[tkc_pkg::TAP_W-1:0];
        end
        else if (res[RES_W-1])
        begin
            res_tap = {1'b1, {(tkc_pkg::TAP_W-1){1'b0}}};
        end
        else
        begin
            res_tap = {1'b0, {(tkc_pkg::TAP_W-1){1'b1}}};
        end
    end

endmodule

### design/truncated_kernel_convolver_core.sv
// Sequence: the transaction that completes a kernel pair starts the first result;
//   result n takes n+1 products, then a MAC drain, then an emit that waits for a free output register.
// Runs: all results of a run are computed by the one MAC, and no new pair is accepted
//   until the last result of the run has been emitted.
// Reset: rst_n clears the sequencer, counters and output valid at once; the tap
//   memories are not cleared, since every run rewrites them before reading them.
module truncated_kernel_convolver_core #(
    parameter int TAPS      = 64,
    parameter int FRAC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: one kernel tap pair per transaction.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] a_tap, [31:16] b_tap
    // Output stream: one convolution tap per transaction.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_tap
    output logic        m_axis_tlast,   // out_last
    output logic [0:0]  m_axis_tuser    // [0] clipped
);

    localparam int AW = $clog2(TAPS);
    localparam logic [AW-1:0] LAST_IDX = AW'(TAPS - 1);

    tkc_pkg::tkc_state_t state_reg, state_next;

    // load_reg counts stored pairs, n_reg is the result index and k_reg the
    // index into the first kernel within the current result.
    logic [AW-1:0] load_reg, load_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] k_reg, k_next;
    logic          drain_reg, drain_next;

    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_tap_reg;
    logic          out_last_reg;
    logic          out_clip_reg;

    logic          in_accept;
    logic          emit;
    logic [AW-1:0] b_addr;

    tkc_pkg::tkc_mac_ctl_t mac_ctl;

    logic signed [tkc_pkg::TAP_W-1:0] a_q;
    logic signed [tkc_pkg::TAP_W-1:0] b_q;
    logic signed [tkc_pkg::TAP_W-1:0] res_tap;
    logic                             res_clip;

    assign s_axis_tready = (state_reg == tkc_pkg::ST_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // A finished result moves into the output register once that register
    // is empty or is being emptied in the same cycle.
    assign emit   = (state_reg == tkc_pkg::ST_EMIT) && (!out_valid_reg || m_axis_tready);
    assign b_addr = n_reg - k_reg;

    // Two stores, each with one write and one read port; both are written by each load transaction and
    // read together, a[k] and b[n-k], while products are issued.
    tkc_ram #(
        .WIDTH (tkc_pkg::TAP_W),
        .DEPTH (TAPS)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (load_reg),
        .wr_data (s_axis_tdata[15:0]),
        .rd_en   (mac_ctl.issue),
        .rd_addr (k_reg),
        .rd_data (a_q)
    );

    tkc_ram #(
        .WIDTH (tkc_pkg::TAP_W),
        .DEPTH (TAPS)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (load_reg),
        .wr_data (s_axis_tdata[31:16]),
        .rd_en   (mac_ctl.issue),
        .rd_addr (b_addr),
        .rd_data (b_q)
    );

    tkc_mac #(
        .TAPS      (TAPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .a_q      (a_q),
        .b_q      (b_q),
        .res_tap  (res_tap),
        .res_clip (res_clip)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkc_pkg::ST_LOAD;
            load_reg      <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_reg      <= load_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_tap_reg  <= res_tap;
            out_last_reg <= (n_reg == LAST_IDX);
            out_clip_reg <= res_clip;
        end
    end

    // Sequencer: load all pairs, then for each result issue its products,
    // let the MAC pipeline drain, and hand the rounded sum to the output.
    always_comb
    begin
        state_next    = state_reg;
        load_next     = load_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        drain_next    = drain_reg;
        mac_ctl.issue = 1'b0;
        mac_ctl.clear = 1'b0;

        unique case (state_reg)
            tkc_pkg::ST_LOAD:
            begin
                mac_ctl.clear = 1'b1;
                n_next        = '0;
                k_next        = '0;
                if (in_accept)
                begin
                    if (load_reg == LAST_IDX)
                    begin
                        load_next  = '0;
                        state_next = tkc_pkg::ST_ISSUE;
                    end
                    else
                    begin
                        load_next = load_reg + 1'b1;
                    end
                end
            end
            tkc_pkg::ST_ISSUE:
            begin
                mac_ctl.issue = 1'b1;
                if (k_reg == n_reg)
                begin
                    k_next     = '0;
                    drain_next = 1'b0;
                    state_next = tkc_pkg::ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            tkc_pkg::ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = tkc_pkg::ST_EMIT;
                end
            end
            tkc_pkg::ST_EMIT:
            begin
                if (emit)
                begin
                    mac_ctl.clear = 1'b1;
                    if (n_reg == LAST_IDX)
                    begin
                        state_next = tkc_pkg::ST_LOAD;
                    end
                    else
                    begin
                        n_next     = n_reg + 1'b1;
                        state_next = tkc_pkg::ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = tkc_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_tap_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_clip_reg;

    // The first-kernel index never passes the result index, so n-k stays valid.
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tkc_pkg::ST_ISSUE) |-> (k_reg <= n_reg))
        else $error("first-kernel index ran past the result index");

    // Loading the final result of a run returns the block to loading.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (n_reg == LAST_IDX)) |=> (state_reg == tkc_pkg::ST_LOAD))
        else $error("sequencer did not return to loading after the last result");

    // A result is only ever loaded into an empty or draining output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !emit)
        else $error("pending output transaction overwritten");

    // Pairs are loaded only at the start of a run, never mid-computation.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tkc_pkg::ST_LOAD) |-> (load_reg == '0))
        else $error("load count not cleared during computation");

endmodule
